// ===== hw/rtl/htfd_pkg.sv =====
package htfd_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BUSY    = 2'd1,
    STATUS_CRC_ERR = 2'd2
  } status_t;

  localparam logic [7:0] CRC_POLY   = 8'h31;
  localparam logic [7:0] CRC_INIT   = 8'hFF;
  localparam logic [2:0] DATA_BYTES = 3'd6;
  localparam int         BUSY_BIT   = 7;

  // Conversion scale factors (raw values are full scale at 2^20)
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_SCALE  = 15'd20000;
  localparam logic [14:0] TEMP_OFFSET = 15'd5000;
  localparam int          RAW_W       = 20;

  // Checksum-stage result handed to the conversion stage
  typedef struct packed {
    status_t           status;
    logic [RAW_W-1:0]  raw_humidity;
    logic [RAW_W-1:0]  raw_temperature;
  } frame_res_t;

  // CRC-8, MSB first, one byte per call
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/humidity_temp_frame_decoder.sv =====
// A result is registered in the checksum stage, then in the output register.
// Throughput without back-pressure: one byte per cycle; the frame registers, the
// checksum stage and the conversion stage (two multiplies per reading) each take a
// request every cycle. Bytes 0-5 give no result; byte 6 gives exactly one.
// Reset (rst_n low, synchronous): byte count 0, CRC 0xFF, collected bytes 0, no result held.
module humidity_temp_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [19:0] raw_humidity, [39:20] raw_temperature,
                                  // [53:40] humidity_centi, [68:54] temperature_centi,
                                  // [71:69] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  logic                  acc;
  logic                  res_valid;
  logic                  res_ready;
  htfd_pkg::frame_res_t  res;

  // Accept whenever the checksum stage can move on
  assign in_tready = !res_valid || res_ready;
  assign acc       = in_tvalid && in_tready;

  htfd_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc         (acc),
    .rx_byte     (in_tdata),
    .frame_start (in_tuser),
    .res_ready   (res_ready),
    .res_valid   (res_valid),
    .res         (res)
  );

  htfd_conv u_conv (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== hw/rtl/htfd_frame.sv =====
module htfd_frame (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  logic [7:0]            rx_byte,
  input  logic                  frame_start,
  input  logic                  res_ready,
  output logic                  res_valid,
  output htfd_pkg::frame_res_t  res
);

  logic [2:0]            byte_count_r, byte_count_nxt;
  logic [7:0]            crc_r, crc_nxt;
  logic [47:0]           bytes_r, bytes_nxt;
  logic                  res_valid_r;
  htfd_pkg::frame_res_t  res_r, res_nxt;

  logic [2:0]  cnt_eff;
  logic [7:0]  crc_eff;
  logic [47:0] bytes_eff;
  logic        is_chk;

  // Restart the frame on a start flag, then either collect or check
  always_comb begin
    cnt_eff   = frame_start ? 3'd0 : byte_count_r;
    crc_eff   = frame_start ? htfd_pkg::CRC_INIT : crc_r;
    bytes_eff = frame_start ? 48'd0 : bytes_r;
    is_chk    = (cnt_eff >= htfd_pkg::DATA_BYTES);

    byte_count_nxt = byte_count_r;
    crc_nxt        = crc_r;
    bytes_nxt      = bytes_r;
    res_nxt        = res_r;

    if (acc) begin
      if (!is_chk) begin
        byte_count_nxt = cnt_eff + 3'd1;
        crc_nxt        = htfd_pkg::crc8_step(crc_eff, rx_byte);
        bytes_nxt      = {bytes_eff[39:0], rx_byte};
      end else begin
        byte_count_nxt = 3'd0;
        crc_nxt        = htfd_pkg::CRC_INIT;
        bytes_nxt      = 48'd0;
        res_nxt.raw_humidity    = '0;
        res_nxt.raw_temperature = '0;
        if (bytes_eff[40 + htfd_pkg::BUSY_BIT]) begin
          res_nxt.status = htfd_pkg::STATUS_BUSY;
        end else if (crc_eff != rx_byte) begin
          res_nxt.status = htfd_pkg::STATUS_CRC_ERR;
        end else begin
          res_nxt.status          = htfd_pkg::STATUS_OK;
          res_nxt.raw_humidity    = bytes_eff[39:20];
          res_nxt.raw_temperature = bytes_eff[19:0];
        end
      end
    end
  end

  // Frame state and result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= 3'd0;
      crc_r        <= htfd_pkg::CRC_INIT;
      bytes_r      <= 48'd0;
      res_valid_r  <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      crc_r        <= crc_nxt;
      bytes_r      <= bytes_nxt;
      if (acc) begin
        res_valid_r <= is_chk;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// ===== hw/rtl/htfd_conv.sv =====
module htfd_conv (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  res_valid,
  input  htfd_pkg::frame_res_t  res,
  output logic                  res_ready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [71:0]           out_tdata,
  output logic [1:0]            out_tuser
);

  logic        out_valid_r;
  logic [71:0] tdata_r, tdata_nxt;
  logic [1:0]  tuser_r, tuser_nxt;

  logic [33:0]        hum_prod;
  logic [34:0]        temp_prod;
  logic [13:0]        hum_centi;
  logic signed [14:0] temp_centi;

  assign res_ready = !out_valid_r || out_tready;

  // Scale raw readings to hundredths
  always_comb begin
    hum_prod   = {14'd0, res.raw_humidity} * {20'd0, htfd_pkg::HUM_SCALE};
    temp_prod  = {15'd0, res.raw_temperature} * {20'd0, htfd_pkg::TEMP_SCALE};
    hum_centi  = hum_prod[33:20];
    if (res.status == htfd_pkg::STATUS_OK) begin
      temp_centi = $signed(temp_prod[34:20] - htfd_pkg::TEMP_OFFSET);
    end else begin
      temp_centi = '0;
    end
    tdata_nxt = {3'd0, temp_centi, hum_centi, res.raw_temperature, res.raw_humidity};
    tuser_nxt = res.status;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      tdata_r <= tdata_nxt;
      tuser_r <= tuser_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = tdata_r;
  assign out_tuser  = tuser_r;

endmodule

// ===== hw/rtl/htfd_checker.sv =====
module htfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // Hold a stalled request
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Clear the output after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Drop all readings on busy or checksum error
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != htfd_pkg::STATUS_OK) |-> out_tdata == 72'd0)
    else $error("readings not cleared on failed frame");

  // Keep status, humidity and the zero pad bits in range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != 2'd3) && (out_tdata[53:40] <= 14'd9999)
                   && (out_tdata[71:69] == 3'd0))
    else $error("result out of range");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_htfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/humidity_temp_frame_checker.sv =====
`timescale 1ns / 100ps

module humidity_temp_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] frame_start
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,  // [19:0] raw_humidity, [39:20] raw_temperature,
                                  // [53:40] humidity_centi, [68:54] temperature_centi,
                                  // [71:69] zero
  input  logic [1:0]  out_tuser,  // [1:0] status
  output int          fail_count,
  output int          pending
);

  typedef struct {
    htfd_pkg::status_t  status;
    logic [19:0]        raw_hum;
    logic [19:0]        raw_temp;
    logic [13:0]        hum_centi;
    logic signed [14:0] temp_centi;
  } reading_t;

  // Own copy of the frame state
  logic [2:0]  frame_pos;
  logic [7:0]  frame_crc;
  logic [47:0] frame_body;

  reading_t pending_readings[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // CRC-8, MSB first, over one byte
  function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ htfd_pkg::CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  task automatic restart_frame();
    frame_pos  = '0;
    frame_crc  = htfd_pkg::CRC_INIT;
    frame_body = '0;
  endtask

  // Fold one accepted byte into the frame; on the checksum byte queue a reading
  task automatic absorb_byte(input logic [7:0] b, input logic start);
    reading_t    r;
    logic [33:0] hum_prod;
    logic [34:0] temp_prod;
    logic [14:0] temp_scaled;
    if (start) begin
      restart_frame();
    end
    if (frame_pos < htfd_pkg::DATA_BYTES) begin
      frame_crc  = crc_next(frame_crc, b);
      frame_body = {frame_body[39:0], b};
      frame_pos  = frame_pos + 3'd1;
    end else begin
      r.status     = htfd_pkg::STATUS_OK;
      r.raw_hum    = '0;
      r.raw_temp   = '0;
      r.hum_centi  = '0;
      r.temp_centi = '0;
      if (frame_body[40 + htfd_pkg::BUSY_BIT]) begin
        r.status = htfd_pkg::STATUS_BUSY;
      end else if (frame_crc != b) begin
        r.status = htfd_pkg::STATUS_CRC_ERR;
      end else begin
        r.raw_hum    = frame_body[39:20];
        r.raw_temp   = frame_body[19:0];
        hum_prod     = 34'(r.raw_hum) * 34'(htfd_pkg::HUM_SCALE);
        temp_prod    = 35'(r.raw_temp) * 35'(htfd_pkg::TEMP_SCALE);
        r.hum_centi  = hum_prod[33:20];
        temp_scaled  = temp_prod[34:20];
        r.temp_centi = temp_scaled - htfd_pkg::TEMP_OFFSET;
      end
      pending_readings.push_back(r);
      restart_frame();
    end
  endtask

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      fail_count++;
    end
  endtask

  // Compare results first, then take in the new request of this edge
  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      restart_frame();
      pending_readings.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_readings.size() == 0) begin
          $error("result with no reading expected: status %0d", out_tuser);
          fail_count++;
        end else begin
          want = pending_readings.pop_front();
          check_field("status", int'(want.status), int'(out_tuser));
          check_field("raw_humidity", int'(want.raw_hum), int'(out_tdata[19:0]));
          check_field("raw_temperature", int'(want.raw_temp), int'(out_tdata[39:20]));
          check_field("humidity_centi", int'(want.hum_centi), int'(out_tdata[53:40]));
          check_field("temperature_centi", int'(want.temp_centi),
                      int'($signed(out_tdata[68:54])));
          check_field("pad", 0, int'(out_tdata[71:69]));
        end
      end
      if (in_tvalid && in_tready) begin
        absorb_byte(in_tdata, in_tuser);
      end
    end
    pending <= pending_readings.size();
  end

endmodule

// ===== tb/tb_humidity_temp_frame_decoder.sv =====
`timescale 1ns / 100ps

module tb_humidity_temp_frame_decoder;

  localparam int RANDOM_BYTES = 1600;
  localparam int HOLD_CYCLES  = 400;

  typedef enum {FRAME_GOOD, FRAME_BUSY, FRAME_BAD_CRC} frame_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;

  int   fail_count;
  int   pending;
  int   burst_left = 0;
  int   bytes_sent = 0;
  logic hold_off_req = 1'b0;

  always #2 clk = ~clk;

  humidity_temp_frame_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  humidity_temp_frame_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Checksum of the six data bytes, used to build well-formed frames
  function automatic logic [7:0] frame_checksum(input logic [47:0] body);
    logic [7:0] c;
    c = htfd_pkg::CRC_INIT;
    for (int k = 5; k >= 0; k--) begin
      c = c ^ body[8*k +: 8];
      for (int i = 0; i < 8; i++) begin
        c = c[7] ? ({c[6:0], 1'b0} ^ htfd_pkg::CRC_POLY) : {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Offer one request; hold it until accepted, with random gaps between bursts
  task automatic offer_byte(input logic [7:0] b, input logic start);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  // Send six data bytes (byte 0 first) and the checksum, optionally spoiled
  task automatic send_frame(input logic [47:0] body, input logic lead_start,
                            input logic [7:0] crc_flip);
    for (int k = 5; k >= 0; k--) begin
      offer_byte(body[8*k +: 8], (k == 5) ? lead_start : 1'b0);
    end
    offer_byte(frame_checksum(body) ^ crc_flip, 1'b0);
  endtask

  // Receiver: changing stall patterns, plus one long hold-off on request
  initial begin
    int mode;
    int span;
    int hold_left;
    bit held;
    hold_left = 0;
    held = 0;
    wait (rst_n);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(10, 150);
      for (int i = 0; i < span; i++) begin
        @(posedge clk);
        if (hold_off_req && !held) begin
          held = 1;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_tready <= 1'b0;
        end else begin
          case (mode)
            0: out_tready <= 1'b1;
            1: out_tready <= 1'($urandom_range(0, 1));
            default: out_tready <= (i % 4 != 3);
          endcase
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin
    frame_kind_t kind;
    logic [47:0] body;
    logic        need_start;
    int          pick;
    int          n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all-zero reading, full-scale reading without start flag,
    // a dropped partial frame, then a busy frame
    send_frame(48'h0, 1'b1, 8'h00);
    send_frame({8'h1C, 40'hFF_FFFF_FFFF}, 1'b0, 8'h00);
    offer_byte(8'h7F, 1'b1);
    send_frame({8'hFF, 40'h00_0000_0000}, 1'b1, 8'h00);

    // Random: mostly well-formed frames, some noise and broken sequences
    hold_off_req <= 1'b1;
    need_start = 1'b0;
    while (bytes_sent < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        kind = (pick < 60) ? FRAME_GOOD : (pick < 73) ? FRAME_BUSY : FRAME_BAD_CRC;
        body = 48'({$urandom, $urandom});
        body[47] = (kind == FRAME_BUSY);
        send_frame(body, need_start | 1'($urandom_range(0, 1)),
                   (kind == FRAME_BAD_CRC) ? 8'($urandom_range(1, 255)) : 8'h00);
        need_start = 1'b0;
      end else begin
        n = $urandom_range(1, 9);
        repeat (n) offer_byte(8'($urandom), $urandom_range(0, 3) == 0);
        need_start = 1'b1;
      end
    end
    in_tvalid <= 1'b0;

    // Drain, then let the pipeline settle
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/htfd_pkg.sv
hw/rtl/htfd_frame.sv
hw/rtl/htfd_conv.sv
hw/rtl/humidity_temp_frame_decoder.sv
hw/rtl/htfd_checker.sv
tb/humidity_temp_frame_checker.sv
tb/tb_humidity_temp_frame_decoder.sv
